[hdl/erdf_pkg.sv]
// Shared types and constants of the event log record deframer.
package erdf_pkg;

  localparam int unsigned CNT_W = 31;

  localparam logic [1:0] REG_SYNC_MARKER = 2'd0;
  localparam logic [1:0] REG_MAX_CHAN_LEN = 2'd1;

  localparam logic [31:0] SYNC_MARKER_RST = 32'hEDA1_DA01;
  localparam logic [15:0] MAX_CHAN_LEN_RST = 16'd999;

  localparam logic [3:0] KIND_HEADER = 4'd0;
  localparam logic [3:0] KIND_CHAN_BYTE = 4'd1;
  localparam logic [3:0] KIND_PAY_BYTE = 4'd2;
  localparam logic [3:0] KIND_DONE = 4'd3;
  localparam logic [3:0] KIND_BAD_CHAN_LEN = 4'd4;
  localparam logic [3:0] KIND_NEG_PAY_LEN = 4'd5;
  localparam logic [3:0] KIND_TRUNCATED = 4'd6;
  localparam logic [3:0] KIND_BAD_TRAILER = 4'd7;
  localparam logic [3:0] KIND_END_IDLE = 4'd8;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         item_kind;
    logic [7:0]         byte_value;
    logic signed [63:0] event_number;
    logic signed [63:0] time_stamp;
    logic signed [31:0] channel_length;
    logic signed [31:0] payload_length;
  } out_item_t;

  typedef struct packed {
    logic [31:0] sync_marker;
    logic [15:0] max_channel_length;
  } cfg_t;

endpackage

[hdl/erdf_fifo.sv]
// Small register queue used on both sides of the deframing engine.
module erdf_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = mem_r[rd_ptr_r];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + CW'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

[hdl/erdf_engine.sv]
// Record deframing engine: marker hunt, header assembly, pass-through and trailer check.
module erdf_engine import erdf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      in_empty,
  input  in_item_t  in_item,
  output logic      in_pop,
  input  logic      out_full,
  output logic      out_push,
  output out_item_t out_item
);

  localparam logic [2:0] PH_HUNT = 3'd0;
  localparam logic [2:0] PH_HEAD = 3'd1;
  localparam logic [2:0] PH_CHAN = 3'd2;
  localparam logic [2:0] PH_PAY = 3'd3;
  localparam logic [2:0] PH_TRAIL = 3'd4;

  logic [2:0]       phase_r, phase_nxt;
  logic [31:0]      shift_r, shift_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [63:0]      hnum_r, hnum_nxt;
  logic [63:0]      htime_r, htime_nxt;
  logic [31:0]      hcl_r, hcl_nxt;
  logic [31:0]      hpl_r, hpl_nxt;
  logic [CNT_W-1:0] cnt_inc;
  logic [31:0]      pl_new;
  logic [31:0]      shift_in;
  logic             take;

  assign take    = !in_empty && !out_full;
  assign in_pop  = take;
  assign cnt_inc = cnt_r + CNT_W'(1);
  assign pl_new  = {hpl_r[23:0], in_item.data_byte};
  assign shift_in = {shift_r[23:0], in_item.data_byte};

  always_comb begin
    phase_nxt = phase_r;
    shift_nxt = shift_r;
    cnt_nxt   = cnt_r;
    hnum_nxt  = hnum_r;
    htime_nxt = htime_r;
    hcl_nxt   = hcl_r;
    hpl_nxt   = hpl_r;
    out_push  = 1'b0;
    out_item  = '0;
    if (take) begin
      if (in_item.end_of_stream) begin
        phase_nxt = PH_HUNT;
        shift_nxt = '0;
        cnt_nxt   = '0;
        out_push  = 1'b1;
        case (phase_r)
          PH_TRAIL:                 out_item.item_kind = KIND_DONE;
          PH_HEAD, PH_CHAN, PH_PAY: out_item.item_kind = KIND_TRUNCATED;
          default:                  out_item.item_kind = KIND_END_IDLE;
        endcase
      end else begin
        case (phase_r)
          PH_HEAD: begin
            cnt_nxt = cnt_inc;
            if (cnt_r < CNT_W'(8)) begin
              hnum_nxt = {hnum_r[55:0], in_item.data_byte};
            end else if (cnt_r < CNT_W'(16)) begin
              htime_nxt = {htime_r[55:0], in_item.data_byte};
            end else if (cnt_r < CNT_W'(20)) begin
              hcl_nxt = {hcl_r[23:0], in_item.data_byte};
            end else begin
              hpl_nxt = pl_new;
            end
            if (cnt_r == CNT_W'(23)) begin
              out_push = 1'b1;
              if (hcl_r == '0 || hcl_r > {16'd0, cfg.max_channel_length}) begin
                phase_nxt = PH_HUNT;
                shift_nxt = '0;
                cnt_nxt   = '0;
                out_item.item_kind      = KIND_BAD_CHAN_LEN;
                out_item.channel_length = hcl_r;
              end else if (pl_new[31]) begin
                phase_nxt = PH_HUNT;
                shift_nxt = '0;
                cnt_nxt   = '0;
                out_item.item_kind      = KIND_NEG_PAY_LEN;
                out_item.payload_length = pl_new;
              end else begin
                phase_nxt = PH_CHAN;
                cnt_nxt   = '0;
                out_item.item_kind      = KIND_HEADER;
                out_item.event_number   = hnum_r;
                out_item.time_stamp     = htime_r;
                out_item.channel_length = hcl_r;
                out_item.payload_length = pl_new;
              end
            end
          end
          PH_CHAN: begin
            out_push = 1'b1;
            out_item.item_kind  = KIND_CHAN_BYTE;
            out_item.byte_value = in_item.data_byte;
            cnt_nxt = cnt_inc;
            if ({1'b0, cnt_inc} >= hcl_r) begin
              cnt_nxt = '0;
              if (hpl_r == '0) begin
                phase_nxt = PH_TRAIL;
                shift_nxt = '0;
              end else begin
                phase_nxt = PH_PAY;
              end
            end
          end
          PH_PAY: begin
            out_push = 1'b1;
            out_item.item_kind  = KIND_PAY_BYTE;
            out_item.byte_value = in_item.data_byte;
            cnt_nxt = cnt_inc;
            if ({1'b0, cnt_inc} >= hpl_r) begin
              phase_nxt = PH_TRAIL;
              cnt_nxt   = '0;
              shift_nxt = '0;
            end
          end
          PH_TRAIL: begin
            shift_nxt = shift_in;
            cnt_nxt   = cnt_inc;
            if (cnt_r == CNT_W'(3)) begin
              out_push  = 1'b1;
              shift_nxt = '0;
              cnt_nxt   = '0;
              if (shift_in == cfg.sync_marker) begin
                phase_nxt = PH_HEAD;
                out_item.item_kind = KIND_DONE;
              end else begin
                phase_nxt = PH_HUNT;
                out_item.item_kind = KIND_BAD_TRAILER;
              end
            end
          end
          default: begin
            // hunt for the sync marker; unused phase codes restart the hunt from a clear register
            if (phase_r == PH_HUNT) begin
              shift_nxt = shift_in;
            end else begin
              shift_nxt = {24'd0, in_item.data_byte};
            end
            phase_nxt = PH_HUNT;
            cnt_nxt   = '0;
            if (shift_nxt == cfg.sync_marker) begin
              phase_nxt = PH_HEAD;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      shift_r <= '0;
      cnt_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      shift_r <= shift_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hnum_r  <= hnum_nxt;
    htime_r <= htime_nxt;
    hcl_r   <= hcl_nxt;
    hpl_r   <= hpl_nxt;
  end

  a_end_hunts: assert property (@(posedge clk) disable iff (!rst_n)
    take && in_item.end_of_stream |=> phase_r == PH_HUNT && cnt_r == '0 && shift_r == '0)
    else $error("end of stream did not return to hunting");

  a_head_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_HEAD |-> cnt_r < CNT_W'(24))
    else $error("header byte count overran");

  a_chan_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_CHAN |-> {1'b0, cnt_r} < hcl_r)
    else $error("channel byte count overran");

  a_trail_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_TRAIL |-> cnt_r < CNT_W'(4))
    else $error("trailer byte count overran");

endmodule

[hdl/event_log_record_deframer_unit.sv]
// Top level of the event log record deframer.
// Takes one log stream byte (or an end-of-stream tick) per request and emits at most one
// result per request: headers, channel and payload bytes, record completion and errors.
// Throughput is one request per clock cycle: the deframing engine settles one byte per
// cycle in its phase machine, fed from a short input queue and feeding a short result
// queue. Each byte is registered in the input queue, its result in the result queue. The
// engine stalls only while the result queue is full. Configuration is written through
// cfg_*, which is always ready; index 0 is the sync marker, index 1 the largest channel
// length, and other indexes are ignored. Write configuration only while the block is idle.
module event_log_record_deframer_unit import erdf_pkg::*; #(
  parameter int unsigned IN_DEPTH  = 2,
  parameter int unsigned OUT_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  in_item_t    in_item,
  output logic        out_empty,
  input  logic        out_pop,
  output out_item_t   out_item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  logic [31:0] sync_marker_r;
  logic [15:0] max_chan_len_r;
  cfg_t        cfg;
  logic        iq_empty, iq_pop;
  in_item_t    iq_item;
  logic        oq_full, oq_push;
  out_item_t   oq_item;

  assign cfg_ready = 1'b1;
  assign cfg.sync_marker        = sync_marker_r;
  assign cfg.max_channel_length = max_chan_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_marker_r  <= SYNC_MARKER_RST;
      max_chan_len_r <= MAX_CHAN_LEN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SYNC_MARKER:  sync_marker_r  <= cfg_wdata;
        REG_MAX_CHAN_LEN: max_chan_len_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  erdf_fifo #(
    .WIDTH ($bits(in_item_t)),
    .DEPTH (IN_DEPTH)
  ) u_in_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_push),
    .wr_data (in_item),
    .full    (in_full),
    .rd_en   (iq_pop),
    .rd_data (iq_item),
    .empty   (iq_empty)
  );

  erdf_engine u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_empty (iq_empty),
    .in_item  (iq_item),
    .in_pop   (iq_pop),
    .out_full (oq_full),
    .out_push (oq_push),
    .out_item (oq_item)
  );

  erdf_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (oq_push),
    .wr_data (oq_item),
    .full    (oq_full),
    .rd_en   (out_pop),
    .rd_data (out_item),
    .empty   (out_empty)
  );

endmodule
